### src/u8lfc_pkg.sv
package u8lfc_pkg;

	localparam int unsigned CP_W = 21;

	localparam logic [7:0] BYTE_CR = 8'h0D;
	localparam logic [7:0] BYTE_LF = 8'h0A;

	localparam logic [CP_W-1:0] CP_MIN_LEN1  = 21'h00080;
	localparam logic [CP_W-1:0] CP_MIN_LEN2  = 21'h00800;
	localparam logic [CP_W-1:0] CP_MIN_LEN3  = 21'h10000;
	localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;
	localparam logic [CP_W-1:0] CP_SURR_LO   = 21'h0D800;
	localparam logic [CP_W-1:0] CP_SURR_HI   = 21'h0DFFF;

	typedef enum logic [1:0] {
		LINE_OK       = 2'd0,
		LINE_FRAMING  = 2'd1,
		LINE_ENCODING = 2'd2
	} line_status_t;

	typedef struct packed {
		logic [1:0]      pending;
		logic [1:0]      seq_len;
		logic [CP_W-1:0] acc;
		logic            frame_err;
		logic            enc_err;
	} line_state_t;

endpackage

### src/u8lfc_decode.sv
module u8lfc_decode
	import u8lfc_pkg::*;
(
	input  line_state_t  cur,
	input  logic [7:0]   data_byte,
	input  logic         has_byte,
	input  logic         last_byte,
	output line_state_t  nxt,
	output line_status_t line_status
);

	logic            take;
	logic            bad_cp;
	logic [1:0]      pend_dec;
	logic [CP_W-1:0] acc_sh;
	line_state_t     st;

	assign take     = has_byte && !(last_byte && (data_byte == BYTE_CR));
	assign acc_sh   = {cur.acc[CP_W-7:0], data_byte[5:0]};
	assign pend_dec = cur.pending - 2'd1;

	always_comb begin
		bad_cp = 1'b0;
		if ((cur.seq_len == 2'd1) && (acc_sh < CP_MIN_LEN1)) bad_cp = 1'b1;
		if ((cur.seq_len == 2'd2) && (acc_sh < CP_MIN_LEN2)) bad_cp = 1'b1;
		if ((cur.seq_len == 2'd3) && (acc_sh < CP_MIN_LEN3)) bad_cp = 1'b1;
		if (acc_sh > CP_MAX) bad_cp = 1'b1;
		if ((acc_sh >= CP_SURR_LO) && (acc_sh <= CP_SURR_HI)) bad_cp = 1'b1;
	end

	always_comb begin
		st = cur;
		if (take) begin
			if ((data_byte == BYTE_CR) || (data_byte == BYTE_LF)) st.frame_err = 1'b1;
			if (cur.pending != 2'd0) begin
				if (data_byte[7:6] != 2'b10) begin
					st.enc_err = 1'b1;
					st.pending = 2'd0;
					st.seq_len = 2'd0;
					st.acc     = '0;
				end else begin
					st.pending = pend_dec;
					st.acc     = acc_sh;
					if (pend_dec == 2'd0) begin
						if (bad_cp) st.enc_err = 1'b1;
						st.seq_len = 2'd0;
						st.acc     = '0;
					end
				end
			end else if (data_byte[7] == 1'b0) begin
				st.acc = cur.acc;
			end else if (data_byte[7:5] == 3'b110) begin
				if (data_byte[4:0] == 5'd0) begin
					st.enc_err = 1'b1;
					st.seq_len = 2'd0;
					st.acc     = '0;
				end else begin
					st.acc     = {{(CP_W-5){1'b0}}, data_byte[4:0]};
					st.seq_len = 2'd1;
					st.pending = 2'd1;
				end
			end else if (data_byte[7:4] == 4'b1110) begin
				st.acc     = {{(CP_W-4){1'b0}}, data_byte[3:0]};
				st.seq_len = 2'd2;
				st.pending = 2'd2;
			end else if (data_byte[7:3] == 5'b11110) begin
				st.acc     = {{(CP_W-3){1'b0}}, data_byte[2:0]};
				st.seq_len = 2'd3;
				st.pending = 2'd3;
			end else begin
				st.enc_err = 1'b1;
				st.seq_len = 2'd0;
				st.acc     = '0;
			end
		end
		if (last_byte && (st.pending != 2'd0)) st.enc_err = 1'b1;
	end

	always_comb begin
		if (st.frame_err) begin
			line_status = LINE_FRAMING;
		end else if (st.enc_err) begin
			line_status = LINE_ENCODING;
		end else begin
			line_status = LINE_OK;
		end
	end

	assign nxt = last_byte ? line_state_t'('0) : st;

endmodule

### src/utf8_line_frame_checker.sv
// utf8_line_frame_checker
//
// input stream: one byte of a text line per request. s_axis_tdata[7:0] is the
// byte, s_axis_tuser is set when the byte is real (clear only on an empty
// line, together with tlast), s_axis_tlast marks the final request of a line.
// output stream: one request per line, m_axis_tdata[1:0] is the status
// (0 valid, 1 embedded cr or lf, 2 invalid utf-8), upper bits zero.
//
// throughput: one input request per cycle while s_axis_tready is high; the
// decode step between the input register and the line state register is
// combinational. a line's status passes the input register, then the result
// register, which loads it when the line's last request advances.
// when the receiver stalls, the result holds in the output register and one
// more line-end request may wait in the input register; only then does
// s_axis_tready drop. ordinary bytes keep flowing while a result waits.
// reset clears the line state and both valid flags at once.
module utf8_line_frame_checker
	import u8lfc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
	input  logic       s_axis_tuser,   // [0] has_byte
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata    // [1:0] line_status, [7:2] zero
);

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         has_s1;
	logic         last_s1;
	line_state_t  state_q;
	line_state_t  state_nxt;
	line_status_t status_nxt;
	line_status_t status_q;
	logic         out_valid_q;
	logic         advance;

	assign advance       = valid_s1 && (!last_s1 || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			has_s1  <= s_axis_tuser;
			last_s1 <= s_axis_tlast;
		end
	end

	u8lfc_decode u_decode (
		.cur         (state_q),
		.data_byte   (byte_s1),
		.has_byte    (has_s1),
		.last_byte   (last_s1),
		.nxt         (state_nxt),
		.line_status (status_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) state_q <= state_nxt;
			if (out_valid_q && m_axis_tready) out_valid_q <= 1'b0;
			if (advance && last_s1) out_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) status_q <= status_nxt;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, status_q};

endmodule

### src/u8lfc_checker.sv
module u8lfc_checker
	import u8lfc_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic       s_axis_tlast,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[7:2] == 6'd0) &&
			((m_axis_tdata[1:0] == LINE_OK) || (m_axis_tdata[1:0] == LINE_FRAMING) ||
			 (m_axis_tdata[1:0] == LINE_ENCODING)))
		else $error("bad status code");

	// a fresh result follows an accepted line-end request
	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))
		else $error("result without line end");

	// input only backs up behind a waiting result
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with output free");

endmodule

bind utf8_line_frame_checker u8lfc_checker u_u8lfc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
